// ===== src/bdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, command codes and status codes of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int CAP_W       = 5;
	localparam int CMD_W       = 3;
	localparam int WORD_W      = 32;
	localparam int ST_W        = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = 3'd5;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

endpackage
`default_nettype wire

// ===== src/bdq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ram
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_ram
	import bdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int PW    = 4
) (
	input  wire  logic                     clk,
	input  wire  logic                     we,
	input  wire  logic [PW-1:0]            waddr,
	input  wire  logic signed [WORD_W-1:0] wdata,
	input  wire  logic                     re,
	input  wire  logic [PW-1:0]            raddr,
	output logic signed [WORD_W-1:0]       rdata
);

	logic signed [WORD_W-1:0] mem [DEPTH];
	logic signed [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/bounded_double_ended_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Ring-buffer deque of signed words with a writable capacity limit.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata: cmd[2:0], value[34:3]
//   m_*      out  m_tvalid/m_tready    m_tdata: status[1:0], read_value[33:2]
//   cfg_*    in   cfg_valid/cfg_ready  cfg_data: capacity[4:0]
//
// One request per cycle while the output is not stalled; its result can be taken
// once the output register holds it (the RAM read registers at the accepting edge,
// the output register loads from it when the result stage advances).
// Pointers and occupancy update at acceptance; the RAM is written the same edge.
// Reset clears pointers and occupancy and sets capacity to 10; entries are unset.
// A stalled output holds the result stage, which then holds the input.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
	import bdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire  logic                   clk,
	input  wire  logic                   arst_n,
	input  wire  logic                   s_tvalid,
	output logic                         s_tready,
	input  wire  logic [IN_TDATA_W-1:0]  s_tdata,   // cmd[2:0], value[34:3]
	output logic                         m_tvalid,
	input  wire  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]       m_tdata,   // status[1:0], read_value[33:2]
	input  wire  logic                   cfg_valid,
	output logic                         cfg_ready,
	input  wire  logic [CAP_W-1:0]       cfg_data
);

	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
	endfunction

	logic [CAP_W-1:0] cap_q;
	logic [PW-1:0]    front_q, rear_q;
	logic [OCC_W-1:0] occ_q;

	logic                     valid_s1, use_ram_s1, empty_peek_s1;
	logic [ST_W-1:0]          status_s1;
	logic                     out_valid_q;
	logic [ST_W-1:0]          out_status_q;
	logic signed [WORD_W-1:0] out_value_q;

	logic [CMD_W-1:0]         cmd;
	logic signed [WORD_W-1:0] value;
	logic                     s_acc, s1_adv;
	logic [LIM_W-1:0]         cap_ext, lim;
	logic                     full, empty;

	logic                     ram_we, ram_re;
	logic [PW-1:0]            ram_waddr, ram_raddr;
	logic signed [WORD_W-1:0] ram_rdata;

	logic [PW-1:0]    front_d, rear_d;
	logic [OCC_W-1:0] occ_d;
	logic [ST_W-1:0]  status_d;
	logic             use_ram_d, empty_peek_d;

	assign cmd   = s_tdata[CMD_W-1:0];
	assign value = s_tdata[CMD_W+WORD_W-1:CMD_W];

	assign cfg_ready = 1'b1;

	assign s1_adv   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;
	assign s_acc    = s_tvalid && s_tready;

	// limit saturates at the storage depth
	assign cap_ext = LIM_W'(cap_q);
	assign lim     = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
	assign full    = LIM_W'(occ_q) >= lim;
	assign empty   = occ_q == '0;

	always_comb begin
		front_d      = front_q;
		rear_d       = rear_q;
		occ_d        = occ_q;
		status_d     = ST_DONE;
		use_ram_d    = 1'b0;
		empty_peek_d = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = front_q;
		ram_re       = 1'b0;
		ram_raddr    = front_q;
		unique case (cmd)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					front_d   = ptr_dec(front_q);
					ram_we    = s_acc;
					ram_waddr = ptr_dec(front_q);
					occ_d     = occ_q + OCC_W'(1);
				end
			end
			CMD_PUSH_REAR: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					rear_d    = ptr_inc(rear_q);
					ram_we    = s_acc;
					ram_waddr = rear_q;
					occ_d     = occ_q + OCC_W'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					front_d = ptr_inc(front_q);
					occ_d   = occ_q - OCC_W'(1);
				end
			end
			CMD_POP_REAR: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rear_d = ptr_dec(rear_q);
					occ_d  = occ_q - OCC_W'(1);
				end
			end
			CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
				if (empty) begin
					status_d     = ST_EMPTY;
					empty_peek_d = 1'b1;
				end else begin
					use_ram_d = 1'b1;
					ram_re    = s_acc;
					ram_raddr = (cmd == CMD_PEEK_FRONT) ? front_q : ptr_dec(rear_q);
				end
			end
			default: begin
			end
		endcase
	end

	bdq_ram #(
		.DEPTH(DEPTH),
		.PW   (PW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			occ_q   <= '0;
		end else if (s_acc) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			occ_q   <= occ_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			status_s1     <= status_d;
			use_ram_s1    <= use_ram_d;
			empty_peek_s1 <= empty_peek_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_status_q <= status_s1;
			if (use_ram_s1) begin
				out_value_q <= ram_rdata;
			end else if (empty_peek_s1) begin
				out_value_q <= EMPTY_WORD;
			end else begin
				out_value_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - ST_W - WORD_W){1'b0}}, out_value_q, out_status_q};

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy above depth");

	a_occ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_acc |=> $stable(occ_q) && $stable(front_q) && $stable(rear_q))
		else $error("queue state moved without an item");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> front_q == rear_q)
		else $error("empty queue with split pointers");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(ram_rdata))
		else $error("result stage dropped while stalled");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == ST_FULL |-> out_value_q == '0)
		else $error("rejected push carries data");
`endif

endmodule
`default_nettype wire
